// ----- hw/rtl/cbe_pkg.sv -----
package cbe_pkg;

  // Backoff timing and field widths.
  localparam int UNIT_BACKOFF_US = 320;
  localparam int UNIT_W          = $clog2(UNIT_BACKOFF_US + 1);
  localparam int EXP_W           = 4;
  localparam int MASK_W          = (1 << EXP_W) - 1;
  localparam int MOD_W           = MASK_W + UNIT_W;
  localparam int RND_W           = 32;
  localparam int CNT_W           = $clog2(RND_W);
  localparam int PERIOD_W        = 17;
  localparam int EXT_W           = (MOD_W > PERIOD_W) ? MOD_W : PERIOD_W;
  localparam int ATT_W           = 3;
  localparam int ACT_W           = 3;
  localparam int OP_W            = 2;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 4;

  localparam int IN_DATA_W  = ((OP_W + RND_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ACT_W + PERIOD_W + ATT_W + 7) / 8) * 8;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
  localparam logic [ATT_W-1:0]    ATT_MAX    = {ATT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_CLEAR = 2'd1,
    OP_BUSY  = 2'd2,
    OP_ERROR = 2'd3
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_WAIT  = 3'd0,
    ACT_TX    = 3'd1,
    ACT_FAIL  = 3'd2,
    ACT_ABORT = 3'd3,
    ACT_IDLE  = 3'd4
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_EXP  = 2'd0,
    REG_MAX_EXP  = 2'd1,
    REG_MAX_BOFF = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

endpackage

// ----- hw/rtl/csma_ca_backoff_engine_core.sv -----
// Channel | Dir | Handshake         | Contents
// in      | in  | tvalid / tready   | op, random_word
// out     | out | tvalid / tready   | action, backoff_period, attempt_count
// cfg     | in  | we (no wait)      | min_exponent, max_exponent, max_backoffs
//
// An item that draws a backoff with a nonzero modulus is accepted, runs 32 steps of the
// shared restoring modulo unit (one remainder bit a cycle), then goes to the hold stage.
// Other items, a zero-modulus draw among them, skip the modulo unit. in_tready is low while an
// item is in work. A result waiting on out_tready does not block the next accept; only a
// second finished result waits in the hold stage. Reset is synchronous, active low.
module csma_ca_backoff_engine_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] op, [33:2] random_word, [39:34] zero
  input  logic [cbe_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] action, [19:3] backoff_period, [22:20] attempt_count, [23] zero
  output logic [cbe_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [cbe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cbe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cbe_pkg::*;

  state_t               state_r, state_nxt;
  logic                 frame_r, frame_nxt;
  logic [ATT_W-1:0]     att_r, att_nxt;
  logic [EXP_W-1:0]     be_r, be_nxt;
  logic [EXP_W-1:0]     min_exp_r, max_exp_r;
  logic [ATT_W-1:0]     max_boff_r;

  logic [MOD_W-1:0]     mod_r, mod_nxt;
  logic [MOD_W-1:0]     rem_r, rem_nxt;
  logic [RND_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  action_t              res_act_r, res_act_nxt;
  logic [PERIOD_W-1:0]  res_per_r, res_per_nxt;
  logic [ATT_W-1:0]     res_att_r, res_att_nxt;

  logic                 out_valid_r, out_valid_nxt;
  action_t              out_act_r;
  logic [PERIOD_W-1:0]  out_per_r;
  logic [ATT_W-1:0]     out_att_r;
  logic                 out_load;

  logic                 accept;
  logic [OP_W-1:0]      in_op;
  logic [RND_W-1:0]     in_rnd;
  logic                 draw;
  logic [EXP_W-1:0]     draw_be;
  logic [EXP_W-1:0]     draw_e;
  logic [MASK_W-1:0]    draw_mask;
  logic [EXP_W:0]       be_inc;
  logic [MOD_W:0]       step_t;
  logic [MOD_W-1:0]     rem_step;
  logic [EXT_W-1:0]     rem_ext;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_op     = in_tdata[OP_W-1:0];
  assign in_rnd    = in_tdata[OP_W +: RND_W];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_att_r, out_per_r, out_act_r});

  // Exponent used by a draw: raised to the minimum, then lowered to the maximum.
  always_comb begin
    draw_e = draw_be;
    if (draw_e < min_exp_r) draw_e = min_exp_r;
    if (draw_e > max_exp_r) draw_e = max_exp_r;
    draw_mask = MASK_W'(({{MASK_W{1'b0}}, 1'b1} << draw_e) - 1'b1);
  end

  assign be_inc = {1'b0, be_r} + 1'b1;

  // One restoring step of the shared modulo unit.
  always_comb begin
    step_t = {rem_r, dvd_r[RND_W-1]};
    if (step_t >= {1'b0, mod_r}) begin
      rem_step = MOD_W'(step_t - {1'b0, mod_r});
    end else begin
      rem_step = step_t[MOD_W-1:0];
    end
    rem_ext = EXT_W'(rem_step);
  end

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    frame_nxt   = frame_r;
    att_nxt     = att_r;
    be_nxt      = be_r;
    mod_nxt     = mod_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    cnt_nxt     = cnt_r;
    res_act_nxt = res_act_r;
    res_per_nxt = res_per_r;
    res_att_nxt = res_att_r;
    draw        = 1'b0;
    draw_be     = be_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_per_nxt = '0;
          if (in_op == OP_START) begin
            frame_nxt   = 1'b1;
            att_nxt     = '0;
            be_nxt      = min_exp_r;
            draw_be     = min_exp_r;
            res_act_nxt = ACT_WAIT;
            draw        = 1'b1;
          end else if (!frame_r) begin
            res_act_nxt = ACT_IDLE;
          end else if (in_op == OP_CLEAR) begin
            res_act_nxt = ACT_TX;
            frame_nxt   = 1'b0;
          end else if (in_op == OP_ERROR) begin
            res_act_nxt = ACT_ABORT;
            frame_nxt   = 1'b0;
          end else begin
            if (be_inc > {1'b0, max_exp_r}) begin
              be_nxt = max_exp_r;
            end else begin
              be_nxt = be_inc[EXP_W-1:0];
            end
            draw_be = be_nxt;
            if (att_r != ATT_MAX) att_nxt = att_r + 1'b1;
            if (att_r >= max_boff_r) begin
              res_act_nxt = ACT_FAIL;
              frame_nxt   = 1'b0;
            end else begin
              res_act_nxt = ACT_WAIT;
              draw        = 1'b1;
            end
          end
          res_att_nxt = att_nxt;

          if (draw && (draw_e != '0)) begin
            mod_nxt   = MOD_W'(draw_mask) * MOD_W'(UNIT_BACKOFF_US);
            rem_nxt   = '0;
            dvd_nxt   = in_rnd;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end else begin
            // A zero modulus gives exactly one unit.
            if (draw) res_per_nxt = PERIOD_W'(UNIT_BACKOFF_US);
            state_nxt = S_HOLD;
          end
        end
      end
      S_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RND_W - 1)) begin
          if (rem_ext < EXT_W'(UNIT_BACKOFF_US)) begin
            res_per_nxt = PERIOD_W'(UNIT_BACKOFF_US);
          end else if (rem_ext > EXT_W'(PERIOD_MAX)) begin
            res_per_nxt = PERIOD_MAX;
          end else begin
            res_per_nxt = rem_ext[PERIOD_W-1:0];
          end
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= 1'b0;
      att_r       <= '0;
      be_r        <= '0;
      out_valid_r <= 1'b0;
      min_exp_r   <= EXP_W'(3);
      max_exp_r   <= EXP_W'(5);
      max_boff_r  <= ATT_W'(4);
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      att_r       <= att_nxt;
      be_r        <= be_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MIN_EXP:  min_exp_r  <= cfg_wdata[EXP_W-1:0];
          REG_MAX_EXP:  max_exp_r  <= cfg_wdata[EXP_W-1:0];
          REG_MAX_BOFF: max_boff_r <= cfg_wdata[ATT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mod_r     <= mod_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    cnt_r     <= cnt_nxt;
    res_act_r <= res_act_nxt;
    res_per_r <= res_per_nxt;
    res_att_r <= res_att_nxt;
    if (out_load) begin
      out_act_r <= res_act_r;
      out_per_r <= res_per_r;
      out_att_r <= res_att_r;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted while the previous item was still in work");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < mod_r))
    else $error("modulo unit remainder reached the modulus");

  a_wait_has_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r == ACT_WAIT) |-> (out_per_r >= PERIOD_W'(UNIT_BACKOFF_US)))
    else $error("wait result carries a period below one unit");

  a_no_period_else: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r != ACT_WAIT) |-> (out_per_r == '0))
    else $error("non-wait result carries a nonzero period");
`endif

endmodule

// ----- verif/tb_csma_ca_backoff_engine_core.sv -----
`timescale 1ns / 100ps

module tb_csma_ca_backoff_engine_core;
  import cbe_pkg::*;

  typedef struct {
    action_t                  action;
    logic [PERIOD_W-1:0]      period;
    logic [ATT_W-1:0]         attempts;
  } csma_outcome_t;

  // Tracks the frame state of the engine and holds the outcomes still owed by it.
  class csma_scoreboard;
    logic [EXP_W-1:0]  min_exp;
    logic [EXP_W-1:0]  max_exp;
    logic [2:0]        max_boff;
    logic [ATT_W-1:0]  attempts;
    logic [EXP_W-1:0]  cur_exp;
    bit                active;
    csma_outcome_t     pending_outcomes[$];
    int                mismatches;

    function new();
      min_exp    = 4'd3;
      max_exp    = 4'd5;
      max_boff   = 3'd4;
      attempts   = '0;
      cur_exp    = '0;
      active     = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MIN_EXP:  min_exp  = val;
        REG_MAX_EXP:  max_exp  = val;
        REG_MAX_BOFF: max_boff = val[2:0];
        default: ;
      endcase
    endfunction

    // The exponent is raised to the minimum first and lowered to the maximum last,
    // so a minimum above the maximum yields the maximum.
    function logic [PERIOD_W-1:0] backoff_for(logic [RND_W-1:0] rnd);
      int unsigned     e;
      longint unsigned modulus;
      longint unsigned wait_us;
      e = cur_exp;
      if (e < min_exp) e = min_exp;
      if (e > max_exp) e = max_exp;
      modulus = ((64'd1 << e) - 64'd1) * UNIT_BACKOFF_US;
      if (modulus == 0) wait_us = UNIT_BACKOFF_US;
      else wait_us = {32'd0, rnd} % modulus;
      if (wait_us < UNIT_BACKOFF_US) wait_us = UNIT_BACKOFF_US;
      if (wait_us > PERIOD_MAX) wait_us = PERIOD_MAX;
      return wait_us[PERIOD_W-1:0];
    endfunction

    function action_t note_item(op_t op, logic [RND_W-1:0] rnd);
      csma_outcome_t    o;
      logic [EXP_W:0]   next_exp;
      bit               over;
      o.action = ACT_IDLE;
      o.period = '0;
      if (op == OP_START) begin
        active   = 1'b1;
        attempts = '0;
        cur_exp  = min_exp;
        o.action = ACT_WAIT;
        o.period = backoff_for(rnd);
      end else if (!active) begin
        o.action = ACT_IDLE;
      end else if (op == OP_CLEAR) begin
        o.action = ACT_TX;
        active   = 1'b0;
      end else if (op == OP_ERROR) begin
        o.action = ACT_ABORT;
        active   = 1'b0;
      end else begin
        next_exp = {1'b0, cur_exp} + 1'b1;
        over     = (attempts >= max_boff);
        if (next_exp > max_exp) next_exp = max_exp;
        cur_exp = next_exp[EXP_W-1:0];
        if (attempts != ATT_MAX) attempts = attempts + 1'b1;
        if (over) begin
          o.action = ACT_FAIL;
          active   = 1'b0;
        end else begin
          o.action = ACT_WAIT;
          o.period = backoff_for(rnd);
        end
      end
      o.attempts = attempts;
      pending_outcomes.push_back(o);
      return o.action;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      csma_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $error("result with no item outstanding: tdata %h", data);
        mismatches++;
        return;
      end
      o = pending_outcomes.pop_front();
      if (data[2:0] !== o.action) begin
        $error("action: expected %0d, got %0d", o.action, data[2:0]);
        mismatches++;
      end
      if (data[19:3] !== o.period) begin
        $error("backoff_period: expected %0d, got %0d", o.period, data[19:3]);
        mismatches++;
      end
      if (data[22:20] !== o.attempts) begin
        $error("attempt_count: expected %0d, got %0d", o.attempts, data[22:20]);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_W-1:0]     in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_W-1:0]    out_tdata;
  logic                     cfg_we;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]    cfg_wdata;

  csma_scoreboard sb;
  int             n_items;
  bit             no_idle;
  bit             hold_req;

  csma_ca_backoff_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_item(op_t op, logic [RND_W-1:0] rnd);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_DATA_W - OP_W - RND_W){1'b0}}, rnd, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(sb.note_item(op, rnd));
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(int min_e, int max_e, int boffs);
    drain();
    repeat (40) @(posedge clk);
    write_reg(REG_MIN_EXP, CFG_DATA_W'(min_e));
    write_reg(REG_MAX_EXP, CFG_DATA_W'(max_e));
    write_reg(REG_MAX_BOFF, CFG_DATA_W'(boffs));
  endtask

  function automatic logic [RND_W-1:0] pick_word();
    logic [RND_W-1:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom_range(0, UNIT_BACKOFF_US - 1);
      1: w = $urandom_range(0, 1) ? '1 : '0;
      2: w = UNIT_BACKOFF_US * $urandom_range(0, 300);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // A start, some busy reports, then mostly a frame end; now and then stray items.
  task automatic random_frame();
    int n_busy;
    send_item(OP_START, pick_word());
    n_busy = $urandom_range(0, 7);
    repeat (n_busy) send_item(OP_BUSY, pick_word());
    case ($urandom_range(0, 3))
      0, 1: send_item(OP_CLEAR, pick_word());
      2: send_item(OP_ERROR, pick_word());
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(op_t'($urandom_range(0, 3)), $urandom);
    end
  endtask

  initial begin
    int phase;
    int min_e;
    int max_e;
    int boffs;
    sb        = new();
    n_items   = 0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_MIN_EXP;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: reports while idle are ignored.
    send_item(OP_CLEAR, '0);
    send_item(OP_BUSY, '1);
    send_item(OP_ERROR, 32'h5555_5555);
    send_item(OP_START, '0);
    send_item(OP_BUSY, '1);
    send_item(OP_BUSY, UNIT_BACKOFF_US - 1);
    // Start while a frame runs, then busy until the retry limit fails it.
    send_item(OP_START, 32'd2239);
    repeat (5) send_item(OP_BUSY, $urandom);
    send_item(OP_START, 32'hAAAA_AAAA);
    send_item(OP_CLEAR, '0);
    send_item(OP_START, $urandom);
    send_item(OP_ERROR, '1);

    // Zero exponent gives a zero modulus; no retries allowed.
    set_config(0, 0, 0);
    send_item(OP_START, '1);
    send_item(OP_BUSY, '1);
    // Widest modulus and the most retries that this bench uses.
    set_config(8, 8, 5);
    send_item(OP_START, '1);
    send_item(OP_BUSY, 32'd81599);
    send_item(OP_CLEAR, $urandom);
    // Minimum above maximum.
    set_config(7, 2, 5);
    send_item(OP_START, $urandom);
    send_item(OP_BUSY, $urandom);
    send_item(OP_ERROR, $urandom);

    phase = 0;
    while (n_items < 700) begin
      phase++;
      if (phase % 4 == 0) begin
        min_e = $urandom_range(0, 1) ? 8 : 0;
        max_e = $urandom_range(0, 1) ? 8 : 0;
        boffs = $urandom_range(0, 1) ? 5 : 0;
      end else begin
        min_e = $urandom_range(0, 8);
        max_e = $urandom_range(0, 8);
        boffs = $urandom_range(0, 5);
      end
      set_config(min_e, max_e, boffs);
      if (phase == 3) hold_req = 1'b1;
      for (int j = 0; j < 8; j++) begin
        if (n_items >= 600) no_idle = 1'b1;
        if (phase == 6 && j == 4) drain();
        random_frame();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
